/* hdl/ftmc_pkg.sv */
package ftmc_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [1:0] OP_PKT   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_TOP      = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] pkt_len;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        first_drop;
    logic [5:0]  entry_index;
    logic [6:0]  flow_count;
    logic [7:0]  top_protocol;
    logic [31:0] top_src_addr;
    logic [31:0] top_dst_addr;
    logic [15:0] top_src_port;
    logic [15:0] top_dst_port;
    logic [31:0] top_packets;
    logic [47:0] top_bytes;
  } out_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] packets;
    logic [47:0] bytes;
  } entry_t;

  typedef struct packed {
    logic   match;
    logic   better;
    entry_t upd;
  } unit_res_t;

  function automatic out_t make_result(logic [2:0] status, logic [31:0] idx,
                                       logic [31:0] cnt, entry_t ent);
    out_t r;
    r.status       = status;
    r.first_drop   = 1'b0;
    r.entry_index  = idx[5:0];
    r.flow_count   = cnt[6:0];
    r.top_protocol = ent.protocol;
    r.top_src_addr = ent.src_addr;
    r.top_dst_addr = ent.dst_addr;
    r.top_src_port = ent.sport;
    r.top_dst_port = ent.dport;
    r.top_packets  = ent.packets;
    r.top_bytes    = ent.bytes;
    return r;
  endfunction

endpackage

/* hdl/flow_table_match_count_top.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------
// item     | start & !busy          | item   (ftmc_pkg::in_t)
// result   | done, one-cycle strobe | result (ftmc_pkg::out_t)
//
// Packet update and top query scan the table through the single memory read
// port, one entry per cycle, over at most the current flow_count entries; a
// packet that matches an entry ends the scan at that entry. Clear and unused
// ops skip the scan and go straight to the finish state.
// busy is low in the cycle done is high, so the next beat may be taken then.
// rst is synchronous; the table contents are not cleared, only the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module flow_table_match_count_top #(
  parameter int TABLE_DEPTH = ftmc_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ftmc_pkg::in_t  item,
  output logic           busy,
  output logic           done,
  output ftmc_pkg::out_t result
);
  import ftmc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic [31:0]   best_pkts;
  logic          best_found;
  in_t           key;
  unit_res_t     unit_res;

  ftmc_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ftmc_unit u_unit (
    .ent        (mem_rdata),
    .key        (key),
    .best_pkts  (best_pkts),
    .best_found (best_found),
    .res        (unit_res)
  );

  ftmc_seq #(.DEPTH(TABLE_DEPTH), .AW(AW), .CW(CW)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item_in    (item),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .best_pkts  (best_pkts),
    .best_found (best_found),
    .key        (key),
    .unit_res   (unit_res)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result strobe without work in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.flow_count) <= 32'(TABLE_DEPTH)))
    else $error("flow count above table depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_DROPPED)) |-> (32'(result.flow_count) == 32'(TABLE_DEPTH)))
    else $error("drop while table not full");
`endif

endmodule

/* hdl/ftmc_mem.sv */
module ftmc_mem #(
  parameter int DEPTH = ftmc_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ftmc_pkg::entry_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output ftmc_pkg::entry_t  rdata
);
  import ftmc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ftmc_unit.sv */
module ftmc_unit (
  input  ftmc_pkg::entry_t    ent,
  input  ftmc_pkg::in_t       key,
  input  logic [31:0]         best_pkts,
  input  logic                best_found,
  output ftmc_pkg::unit_res_t res
);
  import ftmc_pkg::*;

  logic [48:0] byte_sum;
  logic        proto_ok;

  assign byte_sum = {1'b0, ent.bytes} + 49'(key.pkt_len);
  assign proto_ok = (key.protocol == 8'd0) || (ent.protocol == key.protocol);

  always_comb begin
    res.match  = (ent.protocol == key.protocol) && (ent.src_addr == key.src_addr) &&
                 (ent.dst_addr == key.dst_addr) && (ent.sport == key.sport) &&
                 (ent.dport == key.dport);
    res.better = proto_ok && (!best_found || (ent.packets > best_pkts));
    res.upd         = ent;
    res.upd.packets = (ent.packets == PKT_MAX) ? PKT_MAX : ent.packets + 32'd1;
    res.upd.bytes   = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];
  end

endmodule

/* hdl/ftmc_seq.sv */
module ftmc_seq #(
  parameter int DEPTH = ftmc_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ftmc_pkg::in_t       item_in,
  output logic                busy,
  output logic                done,
  output ftmc_pkg::out_t      result,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output ftmc_pkg::entry_t    mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  ftmc_pkg::entry_t    mem_rdata,
  output logic [31:0]         best_pkts,
  output logic                best_found,
  output ftmc_pkg::in_t       key,
  input  ftmc_pkg::unit_res_t unit_res
);
  import ftmc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [1:0]    state;
  in_t           item;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] cmp_idx;
  logic          cmp_valid;
  logic [AW-1:0] best_idx;
  entry_t        best_entry;
  logic [CW-1:0] flow_total;
  logic          overflow_noted;

  logic   scan_end;
  logic   hit;
  logic   is_full;
  logic   insert;
  entry_t new_entry;
  entry_t zero_entry;
  out_t   drop_res;

  assign busy       = (state != S_IDLE);
  assign key        = item;
  assign best_pkts  = best_entry.packets;
  assign is_full    = (flow_total == FULL_CNT);
  assign mem_re     = (state == S_SCAN) && (rd_idx < flow_total);
  assign mem_raddr  = rd_idx[AW-1:0];
  assign scan_end   = (state == S_SCAN) && !cmp_valid && !mem_re;
  assign hit        = (state == S_SCAN) && cmp_valid && (item.op == OP_PKT) && unit_res.match;
  assign insert     = scan_end && (item.op == OP_PKT) && !is_full;
  assign zero_entry = '0;

  always_comb begin
    new_entry          = '0;
    new_entry.protocol = item.protocol;
    new_entry.src_addr = item.src_addr;
    new_entry.dst_addr = item.dst_addr;
    new_entry.sport    = item.sport;
    new_entry.dport    = item.dport;
    new_entry.packets  = 32'd1;
    new_entry.bytes    = 48'(item.pkt_len);
  end

  always_comb begin
    drop_res            = make_result(ST_DROPPED, 32'd0, 32'(flow_total), zero_entry);
    drop_res.first_drop = !overflow_noted;
  end

  assign mem_we    = hit || insert;
  assign mem_waddr = hit ? cmp_idx : flow_total[AW-1:0];
  assign mem_wdata = hit ? unit_res.upd : new_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      cmp_valid      <= 1'b0;
      best_found     <= 1'b0;
      flow_total     <= '0;
      overflow_noted <= 1'b0;
      rd_idx         <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item       <= item_in;
            rd_idx     <= '0;
            cmp_valid  <= 1'b0;
            best_found <= 1'b0;
            state      <= ((item_in.op == OP_PKT) || (item_in.op == OP_QUERY)) ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          cmp_valid <= mem_re;
          cmp_idx   <= rd_idx[AW-1:0];
          if (mem_re) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (cmp_valid && (item.op == OP_QUERY) && unit_res.better) begin
            best_found <= 1'b1;
            best_idx   <= cmp_idx;
            best_entry <= mem_rdata;
          end
          if (hit) begin
            result <= make_result(ST_UPDATED, 32'(cmp_idx), 32'(flow_total), unit_res.upd);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (scan_end) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (item.op == OP_PKT) begin
              if (is_full) begin
                result         <= drop_res;
                overflow_noted <= 1'b1;
              end else begin
                result     <= make_result(ST_INSERTED, 32'(flow_total), 32'(flow_total) + 32'd1,
                                          new_entry);
                flow_total <= flow_total + 1'b1;
              end
            end else if (best_found) begin
              result <= make_result(ST_TOP, 32'(best_idx), 32'(flow_total), best_entry);
            end else begin
              result <= make_result(ST_NONE, 32'd0, 32'(flow_total), zero_entry);
            end
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (item.op == OP_CLEAR) begin
            result         <= make_result(ST_CLEARED, 32'd0, 32'd0, zero_entry);
            flow_total     <= '0;
            overflow_noted <= 1'b0;
          end else begin
            result <= make_result(ST_NONE, 32'd0, 32'(flow_total), zero_entry);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
